>>> hdl/hka_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hka_pkg
// Shared constants and helpers of the hashed key accumulator.
// ----------------------------------------------------------------------------
package hka_pkg;

    localparam int BUCKETS_DEF     = 199;
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int KEY_BITS_DEF    = 20;
    localparam int DATA_W          = 64;
    localparam int INDEX_W         = 8;
    localparam int GROUP_W         = 4;

    // two's complement add, saturated to the signed range
    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] s;
        s = a + b;
        if ((a[DATA_W-1] == b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1]))
        begin
            s = a[DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return s;
    endfunction

endpackage

>>> hdl/hka_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hka_if
// Valid/ready channels of the accumulator: input items and result items.
// ----------------------------------------------------------------------------
interface hka_in_if #(parameter int KEY_BITS = hka_pkg::KEY_BITS_DEF) ();
    logic                             valid;
    logic                             ready;
    logic [KEY_BITS-1:0]              key;
    logic signed [hka_pkg::DATA_W-1:0] amount;

    modport source (output valid, key, amount, input ready);
    modport sink   (input valid, key, amount, output ready);
endinterface

interface hka_out_if ();
    logic                               valid;
    logic                               ready;
    logic [hka_pkg::INDEX_W-1:0]        entry_index;
    logic signed [hka_pkg::DATA_W-1:0]  total;
    logic                               is_new;
    logic                               table_full;

    modport source (output valid, entry_index, total, is_new, table_full, input ready);
    modport sink   (input valid, entry_index, total, is_new, table_full, output ready);
endinterface

>>> hdl/hka_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hka_front
// Accepts items and hashes the key to its bucket (key modulo BUCKETS),
// four key bits per cycle, then pushes the item into the queue.
// ----------------------------------------------------------------------------
module hka_front #(
    parameter int BUCKETS  = hka_pkg::BUCKETS_DEF,
    parameter int KEY_BITS = hka_pkg::KEY_BITS_DEF,
    parameter int BKT_W    = 1,
    parameter int Q_W      = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    hka_in_if.sink         in_ch,
    output logic           push,
    output logic [Q_W-1:0] push_data,
    input  logic           q_full
);
    import hka_pkg::*;

    localparam int NGRP  = (KEY_BITS + GROUP_W - 1) / GROUP_W;
    localparam int KPAD  = NGRP * GROUP_W;
    localparam int CNT_W = $clog2(NGRP + 1);
    localparam int REM_W = BKT_W + 1;

    logic              hold_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [KPAD-1:0]   kshift_reg;
    logic [BKT_W-1:0]  rem_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [DATA_W-1:0] amt_reg;
    logic [BKT_W-1:0]  rem_next;
    logic              done;

    // one group of restoring modulo steps
    always_comb
    begin
        logic [REM_W-1:0] r;
        r = REM_W'(rem_reg);
        for (int j = 0; j < GROUP_W; j++)
        begin
            r = {r[BKT_W-1:0], kshift_reg[KPAD-1-j]};
            if (r >= REM_W'(BUCKETS))
            begin
                r = r - REM_W'(BUCKETS);
            end
        end
        rem_next = r[BKT_W-1:0];
    end

    assign done        = hold_reg && (cnt_reg == CNT_W'(NGRP));
    assign in_ch.ready = !hold_reg;
    assign push        = done && !q_full;
    assign push_data   = {key_reg, amt_reg, rem_reg};

    // item holding and hash sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                hold_reg   <= 1'b1;
                cnt_reg    <= '0;
                rem_reg    <= '0;
                kshift_reg <= KPAD'(in_ch.key);
                key_reg    <= in_ch.key;
                amt_reg    <= in_ch.amount;
            end
            else if (hold_reg && !done)
            begin
                rem_reg    <= rem_next;
                kshift_reg <= kshift_reg << GROUP_W;
                cnt_reg    <= cnt_reg + 1'b1;
            end
            else if (push)
            begin
                hold_reg <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/hka_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hka_queue
// Two-entry queue between the hashing front and the table walker.
// ----------------------------------------------------------------------------
module hka_queue #(
    parameter int Q_W = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic [Q_W-1:0] push_data,
    output logic           full,
    input  logic           pop,
    output logic [Q_W-1:0] pop_data,
    output logic           empty
);
    logic [Q_W-1:0] slot_reg [2];
    logic           wr_reg;
    logic           rd_reg;
    logic [1:0]     cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = slot_reg[rd_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> hdl/hka_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hka_back
// Table walker: reads the bucket head, follows the chain, updates the
// matching total or appends a new entry, and holds the result register.
// ----------------------------------------------------------------------------
module hka_back #(
    parameter int BUCKETS     = hka_pkg::BUCKETS_DEF,
    parameter int MAX_ENTRIES = hka_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = hka_pkg::KEY_BITS_DEF,
    parameter int BKT_W       = 1,
    parameter int Q_W         = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  logic [Q_W-1:0] q_data,
    output logic           pop,
    hka_out_if.source      out_ch
);
    import hka_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PTR_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [PTR_W-1:0] EMPTY = PTR_W'(MAX_ENTRIES);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HEAD, S_CMP, S_INSERT} state_t;

    state_t              state_reg;
    logic [BKT_W-1:0]    clr_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [DATA_W-1:0]   amt_reg;
    logic [BKT_W-1:0]    bkt_reg;
    logic [PTR_W-1:0]    head_ptr_reg;
    logic [PTR_W-1:0]    cur_reg;
    logic [PTR_W-1:0]    steps_reg;
    logic [PTR_W-1:0]    count_reg;
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [DATA_W-1:0]   out_total_reg;
    logic                out_new_reg;
    logic                out_full_reg;

    logic [PTR_W-1:0]    head_mem [BUCKETS];
    logic [KEY_BITS-1:0] ekey_mem [MAX_ENTRIES];
    logic [DATA_W-1:0]   etot_mem [MAX_ENTRIES];
    logic [PTR_W-1:0]    enext_mem [MAX_ENTRIES];
    logic [PTR_W-1:0]    head_rd_reg;
    logic [KEY_BITS-1:0] ekey_rd_reg;
    logic [DATA_W-1:0]   etot_rd_reg;
    logic [PTR_W-1:0]    enext_rd_reg;

    logic [KEY_BITS-1:0] q_key;
    logic [DATA_W-1:0]   q_amt;
    logic [BKT_W-1:0]    q_bkt;
    logic                head_we;
    logic [BKT_W-1:0]    head_waddr;
    logic [PTR_W-1:0]    head_wdata;
    logic [IDX_W-1:0]    ent_raddr;
    logic                ins_we;
    logic                tot_we;
    logic [IDX_W-1:0]    tot_waddr;
    logic [DATA_W-1:0]   tot_wdata;
    logic                hit;
    logic                tbl_full;
    logic                chain_end;
    logic [DATA_W-1:0]   sum;
    logic [31:0]         cur_wide;
    logic [31:0]         cnt_wide;

    assign {q_key, q_amt, q_bkt} = q_data;

    // control decode
    assign pop       = (state_reg == S_IDLE) && !q_empty && (!out_valid_reg || out_ch.ready);
    assign hit       = (ekey_rd_reg == key_reg);
    assign tbl_full  = (count_reg >= EMPTY);
    assign chain_end = (enext_rd_reg == EMPTY) || (steps_reg == PTR_W'(MAX_ENTRIES - 1));
    assign sum       = sat_add(etot_rd_reg, amt_reg);
    assign cur_wide  = 32'(cur_reg);
    assign cnt_wide  = 32'(count_reg);

    assign head_we    = (state_reg == S_CLEAR) || ((state_reg == S_INSERT) && !tbl_full);
    assign head_waddr = (state_reg == S_CLEAR) ? clr_reg : bkt_reg;
    assign head_wdata = (state_reg == S_CLEAR) ? EMPTY : count_reg;
    assign ent_raddr  = (state_reg == S_HEAD) ? head_rd_reg[IDX_W-1:0]
                                              : enext_rd_reg[IDX_W-1:0];
    assign ins_we     = (state_reg == S_INSERT) && !tbl_full;
    assign tot_we     = ins_we || ((state_reg == S_CMP) && hit);
    assign tot_waddr  = ins_we ? count_reg[IDX_W-1:0] : cur_reg[IDX_W-1:0];
    assign tot_wdata  = ins_we ? amt_reg : sum;

    // bucket head memory
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rd_reg <= head_mem[q_bkt];
    end

    // entry memories
    always_ff @(posedge clk)
    begin
        if (ins_we)
        begin
            ekey_mem[count_reg[IDX_W-1:0]]  <= key_reg;
            enext_mem[count_reg[IDX_W-1:0]] <= head_ptr_reg;
        end
        if (tot_we)
        begin
            etot_mem[tot_waddr] <= tot_wdata;
        end
        ekey_rd_reg  <= ekey_mem[ent_raddr];
        etot_rd_reg  <= etot_mem[ent_raddr];
        enext_rd_reg <= enext_mem[ent_raddr];
    end

    // walker state machine and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == BKT_W'(BUCKETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (pop)
                    begin
                        key_reg   <= q_key;
                        amt_reg   <= q_amt;
                        bkt_reg   <= q_bkt;
                        state_reg <= S_HEAD;
                    end
                end
                S_HEAD:
                begin
                    head_ptr_reg <= head_rd_reg;
                    cur_reg      <= head_rd_reg;
                    steps_reg    <= '0;
                    state_reg    <= (head_rd_reg == EMPTY) ? S_INSERT : S_CMP;
                end
                S_CMP:
                begin
                    if (hit)
                    begin
                        out_valid_reg <= 1'b1;
                        out_index_reg <= cur_wide[INDEX_W-1:0];
                        out_total_reg <= sum;
                        out_new_reg   <= 1'b0;
                        out_full_reg  <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                    else if (chain_end)
                    begin
                        state_reg <= S_INSERT;
                    end
                    else
                    begin
                        cur_reg   <= enext_rd_reg;
                        steps_reg <= steps_reg + 1'b1;
                    end
                end
                S_INSERT:
                begin
                    out_valid_reg <= 1'b1;
                    if (tbl_full)
                    begin
                        out_index_reg <= '0;
                        out_total_reg <= '0;
                        out_new_reg   <= 1'b0;
                        out_full_reg  <= 1'b1;
                    end
                    else
                    begin
                        out_index_reg <= cnt_wide[INDEX_W-1:0];
                        out_total_reg <= amt_reg;
                        out_new_reg   <= 1'b1;
                        out_full_reg  <= 1'b0;
                        count_reg     <= count_reg + 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.entry_index = out_index_reg;
    assign out_ch.total       = out_total_reg;
    assign out_ch.is_new      = out_new_reg;
    assign out_ch.table_full  = out_full_reg;

endmodule

>>> hdl/hashed_key_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_key_accumulator_unit
// Keyed accumulator over a chained hash table with saturating Q31.32 totals.
//
// in_ch carries a key and an amount; out_ch returns one item per input:
// the entry index, the new total, a new-entry flag and a table-full flag.
// Both channels use valid/ready; an item moves when both are high.
// The front hashes the key one four-bit group at a time and hands the
// item to a two-entry queue once the queue has room; it takes no new
// item until it has pushed the last one. The walker reads the bucket
// head, then compares one chain entry per step through a registered
// read of the entry memories, and appends a new entry if none matches.
// After reset the bucket heads are cleared, one per cycle, all BUCKETS
// of them (199 by default); items queue up meanwhile and the walker
// starts afterwards. A stalled result stays in the output register; the
// walker takes no queued item until that register is free.
// ----------------------------------------------------------------------------
module hashed_key_accumulator_unit #(
    parameter int BUCKETS     = hka_pkg::BUCKETS_DEF,
    parameter int MAX_ENTRIES = hka_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = hka_pkg::KEY_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    hka_in_if.sink    in_ch,
    hka_out_if.source out_ch
);
    import hka_pkg::*;

    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int Q_W   = KEY_BITS + DATA_W + BKT_W;

    logic           push;
    logic [Q_W-1:0] push_data;
    logic           q_full;
    logic           pop;
    logic [Q_W-1:0] pop_data;
    logic           q_empty;

    // key hashing front
    hka_front #(
        .BUCKETS  (BUCKETS),
        .KEY_BITS (KEY_BITS),
        .BKT_W    (BKT_W),
        .Q_W      (Q_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // decoupling queue
    hka_queue #(
        .Q_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // table walker
    hka_back #(
        .BUCKETS     (BUCKETS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .BKT_W       (BKT_W),
        .Q_W         (Q_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (pop_data),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule
